// File: rtl/dcfb_pkg.sv
`default_nettype none
package dcfb_pkg;

    typedef enum logic [1:0] {
        CMD_COST   = 2'd0,
        CMD_SUPPLY = 2'd1,
        CMD_DEMAND = 2'd2,
        CMD_RUN    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [19:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic [39:0] flow;
        logic        last;
    } t_res;

    localparam logic [1:0] REG_DECAY  = 2'd0;
    localparam logic [1:0] REG_PASSES = 2'd1;
    localparam logic [1:0] REG_ORIG   = 2'd2;
    localparam logic [1:0] REG_DEST   = 2'd3;

    localparam logic [39:0] FLOW_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // 2^(-i/16), Q1.20
    function automatic logic [20:0] pow2_frac(input logic [4:0] idx);
        logic [20:0] t;
        unique case (idx)
            5'd0:  t = 21'd1048576;
            5'd1:  t = 21'd1004120;
            5'd2:  t = 21'd961548;
            5'd3:  t = 21'd920782;
            5'd4:  t = 21'd881744;
            5'd5:  t = 21'd844361;
            5'd6:  t = 21'd808563;
            5'd7:  t = 21'd774282;
            5'd8:  t = 21'd741455;
            5'd9:  t = 21'd710020;
            5'd10: t = 21'd679917;
            5'd11: t = 21'd651091;
            5'd12: t = 21'd623487;
            5'd13: t = 21'd597053;
            5'd14: t = 21'd571740;
            5'd15: t = 21'd547500;
            default: t = 21'd524288;
        endcase
        return t;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_SUM_RD,
        ST_SUM,
        ST_SCALE_RD,
        ST_SCALE_MUL,
        ST_SCALE_DIV,
        ST_SCALE_WR,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: rtl/dcfb_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle: q = (a << 20) / b, saturating to 40 bits.
module dcfb_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [59:0] i_num,
    input  wire logic [47:0] i_den,
    output logic             o_done,
    output logic [39:0]      o_quot
);
    localparam int NBITS = 80;

    logic [79:0] r_num, n_num;
    logic [47:0] r_rem, n_rem;
    logic [79:0] r_quot, n_quot;
    logic [47:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [48:0] w_trial;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_num[79]};
        if (i_start) begin
            n_num  = {i_num, 20'd0};
            n_rem  = '0;
            n_quot = '0;
            n_cnt  = 7'(NBITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[78:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem  = 48'(w_trial - {1'b0, r_den});
                n_quot = {r_quot[78:0], 1'b1};
            end else begin
                n_rem  = w_trial[47:0];
                n_quot = {r_quot[78:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_busy && (r_cnt == 7'd1);
    // final quotient value computed from n_quot on completion
    assign o_quot = (n_quot[79:40] != 40'd0) ? dcfb_pkg::FLOW_MAX : n_quot[39:0];
endmodule
`default_nettype wire

// File: rtl/doubly_constrained_flow_balance.sv
`default_nettype none
// Supply and demand load requests leave busy low; a cost load request holds busy through
// EXP1, EXP2 and EXP3 while the weight is formed. A run request makes pass_limit passes:
// each pass sums the lines entry by entry (SUM_RD then SUM), then rescales each entry
// through one shared 80-step divider, skipped on a zero line sum. Results come one per
// EMIT_RD and EMIT pair, strobed by o_res_valid; the receiver cannot stall. Reset
// (synchronous, active low) restores control, config and sums; other stores are undefined.
module doubly_constrained_flow_balance #(
    parameter int MAX_ORIGINS = 8,
    parameter int MAX_DESTS   = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire dcfb_pkg::t_req         i_req,
    output logic                        o_res_valid,
    output dcfb_pkg::t_res              o_res,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int RW = (MAX_ORIGINS > 1) ? $clog2(MAX_ORIGINS) : 1;
    localparam int CW = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
    // flow store addressed as {row, col}
    localparam int DEPTH = 1 << (RW + CW);
    localparam logic [36:0] LOG2E_EXT = 37'(dcfb_pkg::LOG2E_Q16);

    // configuration
    logic [15:0] r_decay;
    logic [7:0]  r_passes;
    logic [3:0]  r_orig, r_dest;
    logic        w_wr;
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= 16'd4096;
            r_passes <= 8'd10;
            r_orig   <= 4'd8;
            r_dest   <= 4'd8;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                dcfb_pkg::REG_DECAY:  r_decay  <= pwdata[15:0];
                dcfb_pkg::REG_PASSES: r_passes <= pwdata[7:0];
                dcfb_pkg::REG_ORIG:   r_orig   <= pwdata[3:0];
                default:              r_dest   <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dcfb_pkg::REG_DECAY:  prdata = {16'd0, r_decay};
            dcfb_pkg::REG_PASSES: prdata = {24'd0, r_passes};
            dcfb_pkg::REG_ORIG:   prdata = {28'd0, r_orig};
            default:              prdata = {28'd0, r_dest};
        endcase
    end

    // clamped dimensions
    logic [3:0] w_n, w_m;
    always_comb begin
        w_n = (r_orig == 4'd0) ? 4'd1 : ((32'(r_orig) > MAX_ORIGINS) ? 4'(MAX_ORIGINS) : r_orig);
        w_m = (r_dest == 4'd0) ? 4'd1 : ((32'(r_dest) > MAX_DESTS) ? 4'(MAX_DESTS) : r_dest);
    end

    // stores
    logic [39:0] r_flow [DEPTH];
    logic [19:0] r_supply [MAX_ORIGINS];
    logic [19:0] r_demand [MAX_DESTS];
    logic [47:0] r_sums [8];

    dcfb_pkg::t_state r_state, n_state;
    dcfb_pkg::t_req   r_req;
    logic [7:0]  r_pass, n_pass;
    logic [RW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    // r_i/r_j walk the matrix in the sum, scale and emit phases
    logic [36:0] r_x;            // beta*cost
    logic [53:0] r_y;            // x*log2e
    logic [39:0] r_e;            // flow entry read
    logic [47:0] r_s;            // sum for this line
    logic [39:0] r_rd;           // registered memory read
    logic [47:0] r_acc, n_acc;
    logic        r_valid, n_valid;
    logic [2:0]  r_orow, r_ocol;
    logic        r_olast;
    logic [39:0] r_oflow;

    logic w_colpass;
    assign w_colpass = ~r_pass[0];

    logic [RW+CW-1:0] w_addr;
    assign w_addr = {r_i, r_j};

    logic w_last_i, w_last_j;
    assign w_last_i = (32'(r_i) == 32'(w_n) - 1);
    assign w_last_j = (32'(r_j) == 32'(w_m) - 1);

    // entry times line target, fed straight into the divider
    logic [59:0] w_prod;
    assign w_prod = r_e * (w_colpass ? r_demand[r_j] : r_supply[r_i]);

    // divider
    logic        w_div_start, w_div_done;
    logic [39:0] w_quot;
    dcfb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // exponential stage 3 logic
    logic [33:0] w_k;
    logic [19:0] w_f;
    logic [20:0] w_hi, w_lo, w_v;
    logic [36:0] w_dm;
    logic [39:0] w_wt;
    always_comb begin
        w_k  = r_y[53:20] >> 16;
        w_f  = r_y[35:16];
        w_hi = dcfb_pkg::pow2_frac({1'b0, w_f[19:16]});
        w_lo = dcfb_pkg::pow2_frac({1'b0, w_f[19:16]} + 5'd1);
        w_dm = 37'((w_hi - w_lo) * w_f[15:0]);
        w_v  = w_hi - 21'(w_dm >> 16);
        w_wt = (w_k > 34'd20) ? 40'd0 : 40'({19'd0, w_v} >> w_k[4:0]);
    end

    // walk helpers: inner index follows the line direction during sums
    // column pass: outer j, inner i; row pass: outer i, inner j
    logic w_inner_last, w_outer_last;
    assign w_inner_last = w_colpass ? w_last_i : w_last_j;
    assign w_outer_last = w_colpass ? w_last_j : w_last_i;

    logic [2:0] w_line;
    assign w_line = w_colpass ? 3'(r_j) : 3'(r_i);

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_i     = r_i;
        n_j     = r_j;
        n_acc   = r_acc;
        n_valid = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            dcfb_pkg::ST_IDLE: begin
                if (start) begin
                    n_i = '0;
                    n_j = '0;
                    n_acc = '0;
                    n_pass = '0;
                    unique case (dcfb_pkg::t_cmd'(i_req.cmd))
                        dcfb_pkg::CMD_COST: n_state = dcfb_pkg::ST_EXP1;
                        dcfb_pkg::CMD_RUN:
                            n_state = (r_passes == 8'd0) ? dcfb_pkg::ST_EMIT_RD
                                                          : dcfb_pkg::ST_SUM_RD;
                        default: n_state = dcfb_pkg::ST_IDLE;
                    endcase
                end
            end
            dcfb_pkg::ST_EXP1: n_state = dcfb_pkg::ST_EXP2;
            dcfb_pkg::ST_EXP2: n_state = dcfb_pkg::ST_EXP3;
            dcfb_pkg::ST_EXP3: n_state = dcfb_pkg::ST_IDLE;
            dcfb_pkg::ST_SUM_RD: n_state = dcfb_pkg::ST_SUM;
            dcfb_pkg::ST_SUM: begin
                // one entry per SUM_RD and SUM pair, added from the registered read
                n_state = dcfb_pkg::ST_SUM_RD;
                if (w_inner_last) begin
                    n_acc = '0;
                    if (w_colpass) n_i = '0; else n_j = '0;
                    if (w_outer_last) begin
                        n_i = '0;
                        n_j = '0;
                        n_state = dcfb_pkg::ST_SCALE_RD;
                    end else if (w_colpass) begin
                        n_j = r_j + CW'(1);
                    end else begin
                        n_i = r_i + RW'(1);
                    end
                end else begin
                    n_acc = r_acc + 48'(r_rd);
                    if (w_colpass) n_i = r_i + RW'(1); else n_j = r_j + CW'(1);
                end
            end
            dcfb_pkg::ST_SCALE_RD:  n_state = dcfb_pkg::ST_SCALE_MUL;
            dcfb_pkg::ST_SCALE_MUL: begin
                if (r_s == 48'd0) begin
                    n_state = dcfb_pkg::ST_SCALE_WR;
                end else begin
                    w_div_start = 1'b1;
                    n_state = dcfb_pkg::ST_SCALE_DIV;
                end
            end
            dcfb_pkg::ST_SCALE_DIV: begin
                if (w_div_done) n_state = dcfb_pkg::ST_SCALE_WR;
            end
            dcfb_pkg::ST_SCALE_WR: begin
                n_state = dcfb_pkg::ST_SCALE_RD;
                if (w_last_j) begin
                    n_j = '0;
                    if (w_last_i) begin
                        n_i = '0;
                        n_pass = r_pass + 8'd1;
                        n_state = (r_pass + 8'd1 == r_passes) ? dcfb_pkg::ST_EMIT_RD
                                                               : dcfb_pkg::ST_SUM_RD;
                    end else begin
                        n_i = r_i + RW'(1);
                    end
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            dcfb_pkg::ST_EMIT_RD: n_state = dcfb_pkg::ST_EMIT;
            dcfb_pkg::ST_EMIT: begin
                n_valid = 1'b1;
                n_state = dcfb_pkg::ST_EMIT_RD;
                if (w_last_j) begin
                    n_j = '0;
                    if (w_last_i) n_state = dcfb_pkg::ST_IDLE;
                    else n_i = r_i + RW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            default: n_state = dcfb_pkg::ST_IDLE;
        endcase
    end

    // sum walk skips add on the last inner entry above; add it on the line close
    logic [47:0] w_line_sum;
    assign w_line_sum = r_acc + 48'(r_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcfb_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_pass  <= '0;
            for (int k = 0; k < 8; k++) r_sums[k] <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pass  <= n_pass;
            if (r_state == dcfb_pkg::ST_SUM && w_inner_last) r_sums[w_line] <= w_line_sum;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_acc <= n_acc;
        if (r_state == dcfb_pkg::ST_IDLE && start) begin
            r_req <= i_req;
            if (dcfb_pkg::t_cmd'(i_req.cmd) == dcfb_pkg::CMD_SUPPLY && 32'(i_req.row) < MAX_ORIGINS)
                r_supply[RW'(i_req.row)] <= i_req.value;
            if (dcfb_pkg::t_cmd'(i_req.cmd) == dcfb_pkg::CMD_DEMAND && 32'(i_req.col) < MAX_DESTS)
                r_demand[CW'(i_req.col)] <= i_req.value;
        end
        r_x <= 37'(r_decay * r_req.value);
        r_y <= 54'(r_x * LOG2E_EXT);
        if (r_state == dcfb_pkg::ST_EXP3 && 32'(r_req.row) < MAX_ORIGINS
                && 32'(r_req.col) < MAX_DESTS)
            r_flow[{RW'(r_req.row), CW'(r_req.col)}] <= w_wt;
        r_rd <= r_flow[w_addr];
        if (r_state == dcfb_pkg::ST_SCALE_RD) begin
            r_e <= r_flow[w_addr];
            r_s <= r_sums[w_colpass ? 3'(r_j) : 3'(r_i)];
        end
        if (r_state == dcfb_pkg::ST_SCALE_WR && r_s != 48'd0)
            r_flow[w_addr] <= r_oflow;
        if (w_div_done) r_oflow <= w_quot;
        if (r_state == dcfb_pkg::ST_EMIT) begin
            r_orow  <= 3'(r_i);
            r_ocol  <= 3'(r_j);
            r_olast <= w_last_i && w_last_j;
            r_oflow <= r_rd;
        end
    end

    assign busy        = (r_state != dcfb_pkg::ST_IDLE);
    assign o_res_valid = r_valid;
    assign o_res       = '{out_row: r_orow, out_col: r_ocol, flow: r_oflow, last: r_olast};
endmodule
`default_nettype wire

// File: rtl/dcfb_checker.sv
`default_nettype none
module dcfb_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           busy,
    input wire logic           start,
    input wire logic           o_res_valid,
    input wire dcfb_pkg::t_res o_res
);
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy || $past(busy)) else $error("result while idle");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid) else $error("back to back results");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !busy) else $error("busy after last");
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !busy) else $error("busy without a request");
endmodule

bind doubly_constrained_flow_balance dcfb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .start(start),
    .o_res_valid(o_res_valid), .o_res(o_res)
);
`default_nettype wire
